FILE: rtl/wpn_pkg.sv
`default_nettype none
package wpn_pkg;

   // Table depth default.
   localparam int WAYPOINT_DEPTH_DEF = 16;

   // Item kinds carried in the request tuser.
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_ADD    = 3'd1;
   localparam logic [2:0] FUNC_CLEAR  = 3'd2;
   localparam logic [2:0] FUNC_START  = 3'd3;
   localparam logic [2:0] FUNC_TARGET = 3'd4;
   localparam logic [2:0] FUNC_STOP   = 3'd5;

   // Navigation modes.
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_MOVING  = 2'd1;
   localparam logic [1:0] MODE_AVOID   = 2'd2;
   localparam logic [1:0] MODE_REACHED = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_GAIN_P     = 3'd0;
   localparam logic [2:0] REG_GAIN_I     = 3'd1;
   localparam logic [2:0] REG_GAIN_D     = 3'd2;
   localparam logic [2:0] REG_SPEED_LIM  = 3'd3;
   localparam logic [2:0] REG_SPEED_FLR  = 3'd4;
   localparam logic [2:0] REG_ARRIVE     = 3'd5;
   localparam logic [2:0] REG_OBST_LIM   = 3'd6;
   localparam logic [2:0] REG_RUN_EN     = 3'd7;

   // Fixed-point constants.
   localparam logic signed [18:0] PI_Q13      = 19'sd25736;
   localparam logic signed [18:0] TWO_PI_Q13  = 19'sd51472;
   localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic [49:0] SLOW_RANGE_SQ      = 50'd1638400;
   localparam logic signed [24:0] RECIP_FIVE  = 25'sd419431;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 11;

   // Operand and product widths of the shared multiplier.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_LOAD, ST_SQX, ST_SQY, ST_RAD, ST_CHECK, ST_CORDIC,
      ST_ERR, ST_MULP, ST_MULI, ST_MULD, ST_SUM, ST_STEER, ST_SQRT, ST_BMUL,
      ST_BDIV, ST_BASE, ST_DRIVE, ST_DONE
   } wpn_state_type;

   // Arctangent of 2^-i in rad*65536.
   function automatic logic [15:0] atan_step(input logic [3:0] i);
      logic [15:0] v;
      case (i)
         4'd0:    v = 16'd51472;
         4'd1:    v = 16'd30385;
         4'd2:    v = 16'd16055;
         4'd3:    v = 16'd8150;
         4'd4:    v = 16'd4091;
         4'd5:    v = 16'd2047;
         4'd6:    v = 16'd1024;
         4'd7:    v = 16'd512;
         4'd8:    v = 16'd256;
         4'd9:    v = 16'd128;
         4'd10:   v = 16'd64;
         4'd11:   v = 16'd32;
         4'd12:   v = 16'd16;
         4'd13:   v = 16'd8;
         4'd14:   v = 16'd4;
         default: v = 16'd2;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/wpn_mul.sv
`default_nettype none
// Shared signed multiplier with a registered product.
module wpn_mul (
   input  wire logic                                  clock,
   input  wire logic signed [wpn_pkg::MUL_A_W-1:0]    mul_a,
   input  wire logic signed [wpn_pkg::MUL_B_W-1:0]    mul_b,
   output logic signed [wpn_pkg::MUL_P_W-1:0]         mul_q
);

   logic signed [wpn_pkg::MUL_P_W-1:0] prod_ff;

   // The product is registered and ready in the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= wpn_pkg::MUL_P_W'(mul_a) * wpn_pkg::MUL_P_W'(mul_b);
   end

   assign mul_q = prod_ff;

endmodule
`default_nettype wire

FILE: rtl/wpn_cordic.sv
`default_nettype none
// Iterative vectoring CORDIC: one shift-add rotation per cycle, sixteen in all.
module wpn_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [24:0] dx,
   input  wire logic signed [24:0] dy,
   output logic                    done,
   output logic signed [17:0]      bearing
);

   logic signed [35:0] x_ff, y_ff, x_in, y_in, x0, y0, xs, ys;
   logic signed [20:0] z_ff, z_in, zr;
   logic [3:0]         step_ff, step_in;
   logic               run_ff, run_in, done_ff, done_in, zero_ff, zero_in;

   // Load with the quadrant pre-turn, then rotate toward the x axis.
   always_comb begin
      x0 = 36'($signed({dx, 8'b0}));
      y0 = 36'($signed({dy, 8'b0}));
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      run_in = run_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         zero_in = (dx == 25'sd0) && (dy == 25'sd0);
         step_in = 4'd0;
         run_in = 1'b1;
         if (x0 < 0) begin
            if (y0 >= 0) begin
               x_in = y0; y_in = -x0; z_in = wpn_pkg::HALF_PI_Q16;
            end else begin
               x_in = -y0; y_in = x0; z_in = -wpn_pkg::HALF_PI_Q16;
            end
         end else begin
            x_in = x0; y_in = y0; z_in = 21'sd0;
         end
      end else if (run_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + 21'($signed({1'b0, wpn_pkg::atan_step(step_ff)}));
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - 21'($signed({1'b0, wpn_pkg::atan_step(step_ff)}));
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(wpn_pkg::CORDIC_STEPS - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   // Round the angle to Q3.13.
   always_comb begin
      zr = (z_ff + 21'sd4) >>> 3;
      bearing = zero_ff ? 18'sd0 : zr[17:0];
   end

   assign done = done_ff;

endmodule
`default_nettype wire

FILE: rtl/waypoint_heading_pid_navigator_core.sv
`default_nettype none
// Waypoint navigator for a differential-drive base with PID heading control.
// Input words arrive on req_ (tuser holds the item kind, tdata the position,
// heading, obstacle report and waypoint), one result word per input leaves
// on rsp_. Configuration registers are written through csr_; the user must
// write them only while idle, which the block does not enforce. A moving tick
// runs three products, then, if not reached or blocked, a 16-step CORDIC,
// three more products, below a distance of 1280 an 11-step square root and
// two products, and the clamp, all through one shared multiplier and the
// CORDIC shift-add unit. One word is in work at a time; req_tready is high
// only while idle. The result sits in an output register; if the receiver
// stalls, the next word can still be taken, and its result waits until the
// register frees. Reset is synchronous: registers go to their defaults, the
// mode to idle, the table count to zero. Table contents are not cleared.
module waypoint_heading_pid_navigator_core #(
   parameter int WAYPOINT_DEPTH = wpn_pkg::WAYPOINT_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // func
   input  wire logic [2:0]   req_tuser,
   // pos_x, pos_y, heading, obstacle_seen, obstacle_distance, point_x, point_y
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // left_drive, right_drive, drive_valid, nav_state, autonomous_on,
   // waypoint_index, mean_speed, status
   output logic [55:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   localparam int CNT_W = $clog2(WAYPOINT_DEPTH + 1);
   localparam int PTR_W = $clog2(WAYPOINT_DEPTH);

   wpn_pkg::wpn_state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, arrive_ff, obst_lim_ff;
   logic [14:0] lim_ff, floor_ff;
   logic        run_en_ff;

   // Captured request word.
   logic [2:0]   func_ff;
   logic [128:0] req_ff;
   logic signed [23:0] f_pos_x, f_pos_y, f_pt_x, f_pt_y;
   logic signed [15:0] f_heading;
   logic               f_obst;
   logic [15:0]        f_obst_dist;

   // Navigation state.
   logic signed [23:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [15:0] heading_ff, heading_in, prev_ff, prev_in, e_ff, e_in;
   logic signed [31:0] integ_ff, integ_in;
   logic [CNT_W-1:0]   count_ff, count_in, ptr_next;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [1:0]         mode_ff, mode_in;
   logic               auto_ff, auto_in, obst_ff, obst_in, obst_now;
   logic [14:0]        avg_ff, avg_in;

   // Work registers.
   logic signed [24:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [49:0]        s_ff, s_in;
   logic signed [49:0] acc_ff, acc_in, acc_rnd;
   logic signed [36:0] steer_ff, steer_in;
   logic [15:0]        base_ff, base_in, base_fl;
   logic [20:0]        sq_n_ff, sq_n_in, sq_root_ff, sq_root_in, sq_bit_ff, sq_bit_in;
   logic [21:0]        sq_t;
   logic [3:0]         sq_cnt_ff, sq_cnt_in;
   logic signed [15:0] left_ff, left_in, right_ff, right_in;
   logic               dv_ff, dv_in, status_ff, status_in;
   logic signed [18:0] e_raw;
   logic signed [32:0] integ_sum;
   logic signed [37:0] sum_l, sum_r, lim_s;
   logic [16:0]        abs_sum;
   logic signed [15:0] abs_l, abs_r;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   // Table memory.
   logic [47:0]      mem [WAYPOINT_DEPTH];
   logic [47:0]      rd_data_ff;
   logic [PTR_W-1:0] rd_addr;
   logic             mem_we;

   // Shared units.
   logic signed [wpn_pkg::MUL_A_W-1:0] mul_a;
   logic signed [wpn_pkg::MUL_B_W-1:0] mul_b;
   logic signed [wpn_pkg::MUL_P_W-1:0] mul_q;
   logic               cordic_start, cordic_done;
   logic signed [17:0] bearing;

   wpn_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .mul_q(mul_q));

   wpn_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start), .dx(dx_ff), .dy(dy_ff),
      .done(cordic_done), .bearing(bearing)
   );

   // Field views of the captured word.
   always_comb begin
      f_pos_x     = req_ff[23:0];
      f_pos_y     = req_ff[47:24];
      f_heading   = req_ff[63:48];
      f_obst      = req_ff[64];
      f_obst_dist = req_ff[80:65];
      f_pt_x      = req_ff[104:81];
      f_pt_y      = req_ff[128:105];
      obst_now    = f_obst && (f_obst_dist < obst_lim_ff);
      ptr_next    = CNT_W'(ptr_ff) + CNT_W'(1);
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpn_pkg::ST_IDLE:
            if (req_tvalid) state_in = wpn_pkg::ST_DECODE;
         wpn_pkg::ST_DECODE: begin
            state_in = wpn_pkg::ST_DONE;
            case (func_ff)
               wpn_pkg::FUNC_TICK:
                  if (run_en_ff) begin
                     case (mode_ff)
                        wpn_pkg::MODE_IDLE:
                           if (count_ff != '0 && auto_ff) state_in = wpn_pkg::ST_LOAD;
                        wpn_pkg::MODE_MOVING:
                           state_in = wpn_pkg::ST_SQX;
                        wpn_pkg::MODE_REACHED:
                           if (ptr_next < count_ff) state_in = wpn_pkg::ST_LOAD;
                        default: ;
                     endcase
                  end
               wpn_pkg::FUNC_START:
                  if (count_ff != '0) state_in = wpn_pkg::ST_LOAD;
               default: ;
            endcase
         end
         wpn_pkg::ST_LOAD:  state_in = wpn_pkg::ST_DONE;
         wpn_pkg::ST_SQX:   state_in = wpn_pkg::ST_SQY;
         wpn_pkg::ST_SQY:   state_in = wpn_pkg::ST_RAD;
         wpn_pkg::ST_RAD:   state_in = wpn_pkg::ST_CHECK;
         wpn_pkg::ST_CHECK:
            if (s_ff < mul_q[49:0] || obst_ff) state_in = wpn_pkg::ST_DONE;
            else state_in = wpn_pkg::ST_CORDIC;
         wpn_pkg::ST_CORDIC:
            if (cordic_done) state_in = wpn_pkg::ST_ERR;
         wpn_pkg::ST_ERR:   state_in = wpn_pkg::ST_MULP;
         wpn_pkg::ST_MULP:  state_in = wpn_pkg::ST_MULI;
         wpn_pkg::ST_MULI:  state_in = wpn_pkg::ST_MULD;
         wpn_pkg::ST_MULD:  state_in = wpn_pkg::ST_SUM;
         wpn_pkg::ST_SUM:   state_in = wpn_pkg::ST_STEER;
         wpn_pkg::ST_STEER:
            if (s_ff < wpn_pkg::SLOW_RANGE_SQ) state_in = wpn_pkg::ST_SQRT;
            else state_in = wpn_pkg::ST_DRIVE;
         wpn_pkg::ST_SQRT:
            if (sq_cnt_ff == 4'(wpn_pkg::SQRT_STEPS - 1)) state_in = wpn_pkg::ST_BMUL;
         wpn_pkg::ST_BMUL:  state_in = wpn_pkg::ST_BDIV;
         wpn_pkg::ST_BDIV:  state_in = wpn_pkg::ST_BASE;
         wpn_pkg::ST_BASE:  state_in = wpn_pkg::ST_DRIVE;
         wpn_pkg::ST_DRIVE: state_in = wpn_pkg::ST_DONE;
         wpn_pkg::ST_DONE:
            if (!rsp_valid_ff || rsp_tready) state_in = wpn_pkg::ST_IDLE;
         default: state_in = wpn_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and next values.
   always_comb begin
      goal_x_in = goal_x_ff; goal_y_in = goal_y_ff;
      heading_in = heading_ff; prev_in = prev_ff; e_in = e_ff;
      integ_in = integ_ff; count_in = count_ff; ptr_in = ptr_ff;
      mode_in = mode_ff; auto_in = auto_ff; obst_in = obst_ff; avg_in = avg_ff;
      dx_in = dx_ff; dy_in = dy_ff; s_in = s_ff; acc_in = acc_ff;
      steer_in = steer_ff; base_in = base_ff;
      sq_n_in = sq_n_ff; sq_root_in = sq_root_ff; sq_bit_in = sq_bit_ff;
      sq_cnt_in = sq_cnt_ff;
      left_in = left_ff; right_in = right_ff; dv_in = dv_ff; status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0; rd_addr = '0;
      mul_a = '0; mul_b = '0;
      cordic_start = 1'b0;
      req_tready = (state_ff == wpn_pkg::ST_IDLE);
      e_raw = 19'(bearing) - 19'(heading_ff);
      integ_sum = 33'(integ_ff) + 33'(e_ff);
      acc_rnd = acc_ff + 50'sd4096;
      sq_t = 22'(sq_root_ff) + 22'(sq_bit_ff);
      base_fl = (base_ff < 16'(floor_ff)) ? 16'(floor_ff) : base_ff;
      lim_s = 38'(lim_ff);
      sum_l = 38'($signed({1'b0, base_fl})) - 38'(steer_ff);
      sum_r = 38'($signed({1'b0, base_fl})) + 38'(steer_ff);
      abs_l = '0; abs_r = '0; abs_sum = '0;
      case (state_ff)
         wpn_pkg::ST_IDLE:
            if (req_tvalid) begin
               left_in = '0; right_in = '0; dv_in = 1'b0; status_in = 1'b0;
            end
         wpn_pkg::ST_DECODE:
            case (func_ff)
               wpn_pkg::FUNC_TICK: begin
                  heading_in = f_heading;
                  obst_in = obst_now;
                  if (run_en_ff) begin
                     case (mode_ff)
                        wpn_pkg::MODE_IDLE:
                           if (count_ff != '0 && auto_ff) ptr_in = '0;
                        wpn_pkg::MODE_MOVING: begin
                           dx_in = 25'(goal_x_ff) - 25'(f_pos_x);
                           dy_in = 25'(goal_y_ff) - 25'(f_pos_y);
                        end
                        wpn_pkg::MODE_AVOID:
                           if (obst_now) begin
                              left_in = -16'($signed({1'b0, floor_ff}));
                              right_in = 16'($signed({1'b0, floor_ff}));
                              dv_in = 1'b1;
                              avg_in = floor_ff;
                           end else begin
                              mode_in = wpn_pkg::MODE_MOVING;
                           end
                        default: begin
                           left_in = '0; right_in = '0; dv_in = 1'b1; avg_in = '0;
                           if (ptr_next < count_ff) begin
                              ptr_in = ptr_next[PTR_W-1:0];
                              rd_addr = ptr_next[PTR_W-1:0];
                           end else begin
                              mode_in = wpn_pkg::MODE_IDLE;
                              auto_in = 1'b0;
                           end
                        end
                     endcase
                  end
               end
               wpn_pkg::FUNC_ADD:
                  if (count_ff < CNT_W'(WAYPOINT_DEPTH)) begin
                     mem_we = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     status_in = 1'b1;
                  end
               wpn_pkg::FUNC_CLEAR: begin
                  count_in = '0; ptr_in = '0;
               end
               wpn_pkg::FUNC_START:
                  if (count_ff != '0) begin
                     auto_in = 1'b1; ptr_in = '0;
                  end
               wpn_pkg::FUNC_TARGET: begin
                  goal_x_in = f_pt_x; goal_y_in = f_pt_y;
                  mode_in = wpn_pkg::MODE_MOVING;
               end
               wpn_pkg::FUNC_STOP: begin
                  auto_in = 1'b0; mode_in = wpn_pkg::MODE_IDLE;
                  left_in = '0; right_in = '0; dv_in = 1'b1; avg_in = '0;
               end
               default: ;
            endcase
         wpn_pkg::ST_LOAD: begin
            goal_x_in = rd_data_ff[23:0];
            goal_y_in = rd_data_ff[47:24];
            mode_in = wpn_pkg::MODE_MOVING;
         end
         // Squared distance and squared arrival radius.
         wpn_pkg::ST_SQX: begin
            mul_a = 33'(dx_ff); mul_b = dx_ff;
         end
         wpn_pkg::ST_SQY: begin
            mul_a = 33'(dy_ff); mul_b = dy_ff;
            s_in = mul_q[49:0];
         end
         wpn_pkg::ST_RAD: begin
            mul_a = 33'({1'b0, arrive_ff}); mul_b = 25'({1'b0, arrive_ff});
            s_in = s_ff + mul_q[49:0];
         end
         wpn_pkg::ST_CHECK:
            if (s_ff < mul_q[49:0]) mode_in = wpn_pkg::MODE_REACHED;
            else if (obst_ff) mode_in = wpn_pkg::MODE_AVOID;
            else cordic_start = 1'b1;
         // Heading error wrapped into one turn, saturating integral.
         wpn_pkg::ST_CORDIC:
            if (cordic_done) begin
               if (e_raw > wpn_pkg::PI_Q13) e_in = 16'(e_raw - wpn_pkg::TWO_PI_Q13);
               else if (e_raw < -wpn_pkg::PI_Q13) e_in = 16'(e_raw + wpn_pkg::TWO_PI_Q13);
               else e_in = 16'(e_raw);
            end
         wpn_pkg::ST_ERR:
            if (integ_sum > 33'sh0_7FFF_FFFF) integ_in = 32'sh7FFF_FFFF;
            else if (integ_sum < -33'sh0_8000_0000) integ_in = 32'sh8000_0000;
            else integ_in = integ_sum[31:0];
         // PID terms through the shared multiplier.
         wpn_pkg::ST_MULP: begin
            mul_a = 33'(e_ff); mul_b = 25'({1'b0, gain_p_ff});
         end
         wpn_pkg::ST_MULI: begin
            mul_a = 33'(integ_ff); mul_b = 25'({1'b0, gain_i_ff});
            acc_in = mul_q[49:0];
         end
         wpn_pkg::ST_MULD: begin
            mul_a = 33'(17'(e_ff) - 17'(prev_ff)); mul_b = 25'({1'b0, gain_d_ff});
            acc_in = acc_ff + mul_q[49:0];
         end
         wpn_pkg::ST_SUM:
            acc_in = acc_ff + mul_q[49:0];
         wpn_pkg::ST_STEER: begin
            steer_in = acc_rnd[49:13];
            prev_in = e_ff;
            base_in = 16'(lim_ff);
            sq_n_in = s_ff[20:0];
            sq_root_in = '0;
            sq_bit_in = 21'h10_0000;
            sq_cnt_in = '0;
         end
         // One bit pair of the square root per cycle.
         wpn_pkg::ST_SQRT: begin
            if (22'(sq_n_ff) >= sq_t) begin
               sq_n_in = sq_n_ff - sq_t[20:0];
               sq_root_in = (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_in = sq_root_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + 4'd1;
         end
         // Slow-down ramp: limit times distance over 1280.
         wpn_pkg::ST_BMUL: begin
            mul_a = 33'(sq_root_ff[10:0]); mul_b = 25'({1'b0, lim_ff});
         end
         wpn_pkg::ST_BDIV: begin
            mul_a = 33'(mul_q[25:8]); mul_b = wpn_pkg::RECIP_FIVE;
         end
         wpn_pkg::ST_BASE:
            base_in = mul_q[36:21];
         // Clamp both sides and record the mean speed.
         wpn_pkg::ST_DRIVE: begin
            if (sum_l > lim_s) left_in = 16'(lim_s);
            else if (sum_l < -lim_s) left_in = 16'(-lim_s);
            else left_in = 16'(sum_l);
            if (sum_r > lim_s) right_in = 16'(lim_s);
            else if (sum_r < -lim_s) right_in = 16'(-lim_s);
            else right_in = 16'(sum_r);
            abs_l = left_in < 0 ? -left_in : left_in;
            abs_r = right_in < 0 ? -right_in : right_in;
            abs_sum = 17'(unsigned'(abs_l)) + 17'(unsigned'(abs_r));
            avg_in = abs_sum[15:1];
            dv_in = 1'b1;
         end
         wpn_pkg::ST_DONE:
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {status_ff, avg_ff, 4'(ptr_ff), auto_ff, mode_ff, dv_ff,
                              right_ff, left_ff};
            end
         default: ;
      endcase
      if (state_ff == wpn_pkg::ST_DECODE && func_ff == wpn_pkg::FUNC_TICK && run_en_ff &&
          mode_ff == wpn_pkg::MODE_REACHED && ptr_next < count_ff) begin
         rd_addr = ptr_next[PTR_W-1:0];
      end
   end

   // Table memory with a registered read.
   always_ff @(posedge clock) begin
      if (mem_we) mem[count_ff[PTR_W-1:0]] <= {f_pt_y, f_pt_x};
      rd_data_ff <= mem[rd_addr];
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 16'd512; gain_i_ff <= 16'd26; gain_d_ff <= 16'd128;
         lim_ff <= 15'd12800; floor_ff <= 15'd5120; arrive_ff <= 16'd256;
         obst_lim_ff <= 16'd30; run_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            wpn_pkg::REG_GAIN_P:    gain_p_ff <= csr_wdata;
            wpn_pkg::REG_GAIN_I:    gain_i_ff <= csr_wdata;
            wpn_pkg::REG_GAIN_D:    gain_d_ff <= csr_wdata;
            wpn_pkg::REG_SPEED_LIM: lim_ff <= csr_wdata[14:0];
            wpn_pkg::REG_SPEED_FLR: floor_ff <= csr_wdata[14:0];
            wpn_pkg::REG_ARRIVE:    arrive_ff <= csr_wdata;
            wpn_pkg::REG_OBST_LIM:  obst_lim_ff <= csr_wdata;
            wpn_pkg::REG_RUN_EN:    run_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // State and work registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpn_pkg::ST_IDLE;
         goal_x_ff <= '0; goal_y_ff <= '0; heading_ff <= '0; prev_ff <= '0;
         integ_ff <= '0; count_ff <= '0; ptr_ff <= '0;
         mode_ff <= wpn_pkg::MODE_IDLE; auto_ff <= 1'b0; obst_ff <= 1'b0; avg_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         goal_x_ff <= goal_x_in; goal_y_ff <= goal_y_in;
         heading_ff <= heading_in; prev_ff <= prev_in;
         integ_ff <= integ_in; count_ff <= count_in; ptr_ff <= ptr_in;
         mode_ff <= mode_in; auto_ff <= auto_in; obst_ff <= obst_in; avg_ff <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         req_ff <= req_tdata[128:0];
      end
      e_ff <= e_in; dx_ff <= dx_in; dy_ff <= dy_in; s_ff <= s_in; acc_ff <= acc_in;
      steer_ff <= steer_in; base_ff <= base_in;
      sq_n_ff <= sq_n_in; sq_root_ff <= sq_root_in; sq_bit_ff <= sq_bit_in;
      sq_cnt_ff <= sq_cnt_in;
      left_ff <= left_in; right_ff <= right_in; dv_ff <= dv_in; status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/wpn_checker.sv
`default_nettype none
// Port-level checks of the navigator.
module wpn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // One word is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

   // Without a motor command both drives read zero.
   a_no_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("drive values without a command");

   // An ignored add never issues a command.
   a_full_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55] |-> !rsp_tdata[32])
      else $error("command on an ignored add");

endmodule

bind waypoint_heading_pid_navigator_core wpn_checker u_wpn_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

FILE: test/waypoint_heading_pid_navigator_checker.sv
`default_nettype none
module waypoint_heading_pid_navigator_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [2:0]   req_tuser,
   input  wire logic [135:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [55:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = wpn_pkg::WAYPOINT_DEPTH_DEF;

   typedef struct {
      logic [15:0] left_drive;
      logic [15:0] right_drive;
      logic        drive_valid;
      logic [1:0]  nav_state;
      logic        autonomous_on;
      logic [3:0]  waypoint_index;
      logic [14:0] mean_speed;
      logic        status;
   } nav_word_type;

   // Register copies.
   longint gain_p, gain_i, gain_d, speed_limit, speed_floor;
   longint arrive_radius, obstacle_limit;
   bit     run_enable;

   // Navigator state copies.
   longint pos_x, pos_y, head_now, goal_x, goal_y;
   longint table_x [TABLE_DEPTH];
   longint table_y [TABLE_DEPTH];
   int     wp_count, wp_ptr;
   longint err_integral, prev_err, avg_speed;
   logic [1:0] mode;
   bit     auto_flag, obst_flag;

   nav_word_type drive_expect_q[$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Shift-add arctangent of (dy, dx), rounded to Q3.13.
   function automatic longint bearing_of(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      longint steps [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
      if (dx == 0 && dy == 0) return 0;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 102944;
         end else begin
            t = x; x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += steps[i];
         end else begin
            x -= ys; y += xs; z -= steps[i];
         end
      end
      return (z + 4) >>> 3;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic issue_drive(longint l, longint r, inout nav_word_type w);
      longint al, ar;
      al = l < 0 ? -l : l;
      ar = r < 0 ? -r : r;
      avg_speed = ((al + ar) >> 1) & 64'h7FFF;
      w.left_drive = l[15:0];
      w.right_drive = r[15:0];
      w.drive_valid = 1'b1;
   endtask

   task automatic load_goal(int idx);
      goal_x = table_x[idx % TABLE_DEPTH];
      goal_y = table_y[idx % TABLE_DEPTH];
   endtask

   // One control step of the mode machine on a tick.
   task automatic step_navigation(inout nav_word_type w);
      longint dx, dy, e, steer, base, d;
      longint unsigned dist_sq, rad;
      case (mode)
         wpn_pkg::MODE_IDLE: begin
            if (wp_count > 0 && auto_flag) begin
               wp_ptr = 0;
               load_goal(0);
               mode = wpn_pkg::MODE_MOVING;
            end
         end
         wpn_pkg::MODE_MOVING: begin
            dx = goal_x - pos_x;
            dy = goal_y - pos_y;
            dist_sq = dx * dx + dy * dy;
            rad = arrive_radius;
            if (dist_sq < rad * rad) begin
               mode = wpn_pkg::MODE_REACHED;
            end else if (obst_flag) begin
               mode = wpn_pkg::MODE_AVOID;
            end else begin
               e = bearing_of(dx, dy) - head_now;
               while (e > 25736) e -= 51472;
               while (e < -25736) e += 51472;
               err_integral = clip(err_integral + e, -64'sd2147483648, 64'sd2147483647);
               steer = gain_p * e + gain_i * err_integral + gain_d * (e - prev_err);
               steer = (steer + 4096) >>> 13;
               prev_err = e;
               d = longint'(int_sqrt(dist_sq));
               base = d >= 1280 ? speed_limit : (speed_limit * d) / 1280;
               if (base < speed_floor) base = speed_floor;
               issue_drive(clip(base - steer, -speed_limit, speed_limit),
                           clip(base + steer, -speed_limit, speed_limit), w);
            end
         end
         wpn_pkg::MODE_AVOID: begin
            if (obst_flag) issue_drive(-speed_floor, speed_floor, w);
            else mode = wpn_pkg::MODE_MOVING;
         end
         default: begin
            issue_drive(0, 0, w);
            if (wp_ptr + 1 < wp_count) begin
               wp_ptr = (wp_ptr + 1) % TABLE_DEPTH;
               load_goal(wp_ptr);
               mode = wpn_pkg::MODE_MOVING;
            end else begin
               mode = wpn_pkg::MODE_IDLE;
               auto_flag = 0;
            end
         end
      endcase
   endtask

   // Works out the result word for one accepted request word.
   task automatic predict_nav_word(logic [2:0] func, logic [135:0] d,
                                   output nav_word_type w);
      longint px, py;
      w = '{default: '0};
      px = longint'($signed(d[104:81]));
      py = longint'($signed(d[128:105]));
      case (func)
         wpn_pkg::FUNC_TICK: begin
            pos_x = longint'($signed(d[23:0]));
            pos_y = longint'($signed(d[47:24]));
            head_now = longint'($signed(d[63:48]));
            obst_flag = d[64] && (longint'(d[80:65]) < obstacle_limit);
            if (run_enable) step_navigation(w);
         end
         wpn_pkg::FUNC_ADD: begin
            if (wp_count < TABLE_DEPTH) begin
               table_x[wp_count] = px;
               table_y[wp_count] = py;
               wp_count++;
            end else begin
               w.status = 1'b1;
            end
         end
         wpn_pkg::FUNC_CLEAR: begin
            wp_count = 0;
            wp_ptr = 0;
         end
         wpn_pkg::FUNC_START: begin
            if (wp_count > 0) begin
               auto_flag = 1;
               wp_ptr = 0;
               load_goal(0);
               mode = wpn_pkg::MODE_MOVING;
            end
         end
         wpn_pkg::FUNC_TARGET: begin
            goal_x = px;
            goal_y = py;
            mode = wpn_pkg::MODE_MOVING;
         end
         wpn_pkg::FUNC_STOP: begin
            auto_flag = 0;
            mode = wpn_pkg::MODE_IDLE;
            issue_drive(0, 0, w);
         end
         default: ;
      endcase
      w.nav_state = mode;
      w.autonomous_on = auto_flag;
      w.waypoint_index = wp_ptr[3:0];
      w.mean_speed = avg_speed[14:0];
   endtask

   task automatic report(string name, longint want, longint got);
      $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      checked_count = 0;
   end

   // Track register writes, predict on each request word, compare each result word.
   always @(posedge clock) begin
      nav_word_type w, got;
      if (reset) begin
         gain_p = 512; gain_i = 26; gain_d = 128;
         speed_limit = 12800; speed_floor = 5120;
         arrive_radius = 256; obstacle_limit = 30; run_enable = 0;
         pos_x = 0; pos_y = 0; head_now = 0; goal_x = 0; goal_y = 0;
         wp_count = 0; wp_ptr = 0;
         err_integral = 0; prev_err = 0; avg_speed = 0;
         mode = wpn_pkg::MODE_IDLE; auto_flag = 0; obst_flag = 0;
         drive_expect_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               wpn_pkg::REG_GAIN_P:    gain_p = csr_wdata;
               wpn_pkg::REG_GAIN_I:    gain_i = csr_wdata;
               wpn_pkg::REG_GAIN_D:    gain_d = csr_wdata;
               wpn_pkg::REG_SPEED_LIM: speed_limit = csr_wdata[14:0];
               wpn_pkg::REG_SPEED_FLR: speed_floor = csr_wdata[14:0];
               wpn_pkg::REG_ARRIVE:    arrive_radius = csr_wdata;
               wpn_pkg::REG_OBST_LIM:  obstacle_limit = csr_wdata;
               wpn_pkg::REG_RUN_EN:    run_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_nav_word(req_tuser, req_tdata, w);
            drive_expect_q.push_back(w);
         end
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            got.left_drive = rsp_tdata[15:0];
            got.right_drive = rsp_tdata[31:16];
            got.drive_valid = rsp_tdata[32];
            got.nav_state = rsp_tdata[34:33];
            got.autonomous_on = rsp_tdata[35];
            got.waypoint_index = rsp_tdata[39:36];
            got.mean_speed = rsp_tdata[54:40];
            got.status = rsp_tdata[55];
            if (drive_expect_q.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               w = drive_expect_q.pop_front();
               if (got.left_drive != w.left_drive)
                  report("left_drive", $signed(w.left_drive), $signed(got.left_drive));
               if (got.right_drive != w.right_drive)
                  report("right_drive", $signed(w.right_drive), $signed(got.right_drive));
               if (got.drive_valid != w.drive_valid)
                  report("drive_valid", w.drive_valid, got.drive_valid);
               if (got.nav_state != w.nav_state)
                  report("nav_state", w.nav_state, got.nav_state);
               if (got.autonomous_on != w.autonomous_on)
                  report("autonomous_on", w.autonomous_on, got.autonomous_on);
               if (got.waypoint_index != w.waypoint_index)
                  report("waypoint_index", w.waypoint_index, got.waypoint_index);
               if (got.mean_speed != w.mean_speed)
                  report("mean_speed", w.mean_speed, got.mean_speed);
               if (got.status != w.status)
                  report("status", w.status, got.status);
            end
         end
      end
      pending_count = drive_expect_q.size();
   end

endmodule
`default_nettype wire

FILE: test/waypoint_heading_pid_navigator_core_tb.sv
`default_nettype none
module waypoint_heading_pid_navigator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_TARGET = 700;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [2:0]   req_tuser;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [15:0]  csr_wdata;
   int           fail_count, pending_count, checked_count;
   int           items_sent;
   bit           stimulus_done;

   // Waypoints of the current run, so ticks can be placed on or near them.
   logic signed [23:0] route_x[$];
   logic signed [23:0] route_y[$];

   waypoint_heading_pid_navigator_core u_top (.*);

   waypoint_heading_pid_navigator_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: cycles with no word moving on either channel.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Result side: random stalls, bursts with none, and one long hold-off.
   initial begin
      int gap, taken;
      bit burst;
      taken = 0;
      burst = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : $urandom_range(0, 7);
         if (taken == 250) gap = 600;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   function automatic logic [135:0] pack_req(logic signed [23:0] px, logic signed [23:0] py,
                                             logic signed [15:0] hd, logic os,
                                             logic [15:0] od, logic signed [23:0] qx,
                                             logic signed [23:0] qy);
      return {7'd0, qy, qx, od, os, hd, py, px};
   endfunction

   // Offers one request word after a random gap; returns at the falling edge after acceptance.
   task automatic send_word(logic [2:0] func, logic [135:0] data);
      int gap;
      gap = (items_sent % 60 < 15) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_point(logic [2:0] func, logic signed [23:0] qx, logic signed [23:0] qy);
      send_word(func, pack_req(24'($urandom), 24'($urandom), 16'($urandom), 1'($urandom),
                               16'($urandom), qx, qy));
   endtask

   task automatic send_tick(logic signed [23:0] px, logic signed [23:0] py,
                            logic signed [15:0] hd, logic os, logic [15:0] od);
      send_word(wpn_pkg::FUNC_TICK, pack_req(px, py, hd, os, od, 24'($urandom),
                                             24'($urandom)));
   endtask

   function automatic logic signed [15:0] any_heading();
      return 16'($signed($urandom_range(0, 51472)) - 25736);
   endfunction

   // Waits until every result is back and the block is quiet again.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                           logic [15:0] lim, logic [15:0] flr, logic [15:0] rad,
                           logic [15:0] olim, logic [15:0] run);
      drain();
      write_reg(wpn_pkg::REG_GAIN_P, gp);
      write_reg(wpn_pkg::REG_GAIN_I, gi);
      write_reg(wpn_pkg::REG_GAIN_D, gd);
      write_reg(wpn_pkg::REG_SPEED_LIM, lim);
      write_reg(wpn_pkg::REG_SPEED_FLR, flr);
      write_reg(wpn_pkg::REG_ARRIVE, rad);
      write_reg(wpn_pkg::REG_OBST_LIM, olim);
      write_reg(wpn_pkg::REG_RUN_EN, run);
   endtask

   // One well-formed route: load waypoints, start, then ticks around them.
   task automatic drive_route(int span);
      int n, k, ticks;
      logic signed [23:0] wx, wy, px, py;
      n = $urandom_range(1, 6);
      route_x.delete();
      route_y.delete();
      send_point(wpn_pkg::FUNC_CLEAR, 0, 0);
      for (int i = 0; i < n; i++) begin
         wx = 24'($signed($urandom_range(0, 2 * span)) - span);
         wy = 24'($signed($urandom_range(0, 2 * span)) - span);
         route_x.push_back(wx);
         route_y.push_back(wy);
         send_point(wpn_pkg::FUNC_ADD, wx, wy);
      end
      if ($urandom_range(0, 5) == 0)
         send_point(wpn_pkg::FUNC_TARGET, route_x[0], route_y[0]);
      else
         send_point(wpn_pkg::FUNC_START, 0, 0);
      ticks = $urandom_range(8, 20);
      for (int t = 0; t < ticks; t++) begin
         k = $urandom_range(0, n - 1);
         case ($urandom_range(0, 3))
            0: begin
               px = route_x[k]; py = route_y[k];
            end
            1: begin
               px = route_x[k] + 24'($signed($urandom_range(0, 600)) - 300);
               py = route_y[k] + 24'($signed($urandom_range(0, 600)) - 300);
            end
            default: begin
               px = 24'($signed($urandom_range(0, 2 * span)) - span);
               py = 24'($signed($urandom_range(0, 2 * span)) - span);
            end
         endcase
         send_tick(px, py, any_heading(), $urandom_range(0, 4) == 0,
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 60)) : 16'($urandom));
      end
      if ($urandom_range(0, 3) == 0) send_point(wpn_pkg::FUNC_STOP, 0, 0);
   endtask

   // Noise: any kind of word with any field values.
   task automatic send_noise();
      send_word(3'($urandom_range(0, 7)), pack_req(24'($urandom), 24'($urandom),
                any_heading(), 1'($urandom), 16'($urandom), 24'($urandom),
                24'($urandom)));
   endtask

   task automatic random_phase(int count, int span);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else drive_route(span);
      end
   endtask

   initial begin
      items_sent = 0;
      stimulus_done = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: navigation disabled, then each kind of word and the corner cases.
      send_tick(24'sh7FFFFF, 24'sh800000, 16'sd25736, 1'b1, 16'd0);
      send_point(wpn_pkg::FUNC_START, 0, 0);
      send_point(wpn_pkg::FUNC_STOP, 0, 0);
      send_point(FUNC_SPARE_A, 0, 0);
      send_point(FUNC_SPARE_B, 0, 0);
      send_point(wpn_pkg::FUNC_TARGET, 24'sh7FFFFF, 24'sh800000);
      send_point(wpn_pkg::FUNC_CLEAR, 0, 0);
      set_regs(512, 26, 128, 12800, 5120, 256, 30, 1);
      for (int i = 0; i < 16; i++)
         send_point(wpn_pkg::FUNC_ADD, i == 0 ? 24'sh800000 : 24'(i * 300),
                    i == 0 ? 24'sh7FFFFF : 24'(-i * 200));
      send_point(wpn_pkg::FUNC_ADD, 1, 1);
      send_point(wpn_pkg::FUNC_START, 0, 0);
      send_tick(24'sh7FFFFF, 24'sh800000, -16'sd25736, 1'b0, 16'hFFFF);
      send_tick(24'sh800000, 24'sh7FFFFF, 16'sd0, 1'b0, 16'd0);
      send_tick(24'sd0, 24'sd0, 16'sd100, 1'b0, 16'd0);
      send_tick(24'sd300, -24'sd200, 16'sd0, 1'b1, 16'd5);
      send_tick(24'sd0, 24'sd0, 16'sd0, 1'b1, 16'd29);
      send_tick(24'sd0, 24'sd0, 16'sd0, 1'b1, 16'd30);
      send_tick(24'sd0, 24'sd0, 16'sd0, 1'b0, 16'd0);
      send_point(wpn_pkg::FUNC_STOP, 0, 0);
      send_point(wpn_pkg::FUNC_TARGET, 24'sd0, 24'sd0);
      send_tick(24'sd0, 24'sd0, 16'sd0, 1'b0, 16'd0);
      send_tick(24'sd0, 24'sd0, 16'sd0, 1'b0, 16'd0);

      // Random phases over several register settings, extremes among them.
      random_phase(150, 3000);
      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 25600, 25600, 0, 16'hFFFF, 1);
      random_phase(80, 3000);
      set_regs(0, 0, 0, 0, 0, 16'hFFFF, 0, 1);
      random_phase(60, 40000);
      // Sender waits for every result before going on.
      drain();
      set_regs(900, 3, 400, 20000, 30000, 512, 40, 0);
      random_phase(40, 3000);
      set_regs(300, 50, 2000, 25600, 1000, 128, 50, 1);
      random_phase(120, 100000);
      set_regs(512, 26, 128, 12800, 5120, 256, 30, 1);
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else drive_route($urandom_range(0, 1) ? 3000 : 8388607);
      end
      drain();
      stimulus_done = 1;

      $display("Sent %0d request words over six register settings; checked %0d results.",
               items_sent, checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
